[design/raid1_mirror_request_steering_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the mirror request steering core
// Concurrent property wrappers; compile with NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef RAID1_MIRROR_REQUEST_STEERING_CORE_DEFINES_SVH
`define RAID1_MIRROR_REQUEST_STEERING_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define R1MS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// Next-cycle implication
`define R1MS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define R1MS_ASSERT_SAME(label, clk, rst, ante, cons)
`define R1MS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/r1ms_pkg.sv]
// ---------------------------------------------------------------------------
// Mirror request steering package
// Shared constants, transaction types and helper functions.
// ---------------------------------------------------------------------------
package r1ms_pkg;

   localparam int MAX_DISKS   = 8;
   localparam int DISK_IDX_W  = $clog2(MAX_DISKS);
   localparam int DISK_CNT_W  = 4;
   localparam int SECTOR_W    = 32;
   localparam int LEN_W       = 8;
   localparam int DIST_W      = 12;
   localparam logic [DIST_W-1:0] DIST_LIMIT = 12'd4095;

   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 40;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [DISK_CNT_W-1:0] DISK_COUNT_RESET = 4'd2;

   // Classified request held in the queue
   typedef struct packed {
      logic                opcode;
      logic [SECTOR_W-1:0] abs_sector;
      logic [SECTOR_W-1:0] new_head;
   } req_entry_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end status
   typedef struct packed {
      logic idle;
      logic load;
      logic load_read;
   } back_status_type;

   // Clamp the programmed disk count into 1..MAX_DISKS
   function automatic logic [DISK_CNT_W-1:0] eff_count(input logic [DISK_CNT_W-1:0] dc);
      logic [DISK_CNT_W-1:0] n;
      n = dc;
      if (n == '0) begin
         n = DISK_CNT_W'(1);
      end
      if (n > DISK_CNT_W'(MAX_DISKS)) begin
         n = DISK_CNT_W'(MAX_DISKS);
      end
      return n;
   endfunction

endpackage

[design/raid1_mirror_request_steering_core.sv]
// Flow: an accepted request is registered in the front end, queued, and then
//   sequenced by the back end over n disks, n being the effective count (1..8).
// The back end takes the next request only when idle; its sequencer visits one
//   disk per cycle (read scan, or one write result each) unless output stalls.
// Reset: synchronous, active high; clears head positions, tie pointer, queue
//   and handshakes, and sets the disk count to 2.
// ---------------------------------------------------------------------------
// Mirror request steering core
// Steers block requests across a mirrored array: writes to every disk,
// reads to the disk whose head position is nearest.
// ---------------------------------------------------------------------------
`include "raid1_mirror_request_steering_core_defines.svh"

module raid1_mirror_request_steering_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [r1ms_pkg::DISK_CNT_W-1:0] csr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: sector[31:0], partition_start[63:32], length_sectors[71:64]
   input  logic [r1ms_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: disk_index[2:0], disk_sector[34:3], zero fill[39:35]
   output logic [r1ms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import r1ms_pkg::*;

   logic [DISK_CNT_W-1:0] disk_count_ff, disk_count_in;
   queue_status_type      q_status;
   req_entry_type         q_push_data;
   req_entry_type         q_pop_data;
   logic                  q_push;
   logic                  q_pop;
   back_status_type       back_status;

   // Disk count register
   assign csr_ready     = 1'b1;
   assign disk_count_in = (csr_valid && csr_ready) ? csr_data : disk_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_count_ff <= DISK_COUNT_RESET;
      end else begin
         disk_count_ff <= disk_count_in;
      end
   end

   r1ms_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   r1ms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   r1ms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .disk_count (disk_count_ff),
      .q_status   (q_status),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (back_status)
   );

   // The front end never pushes into a full queue
   `R1MS_ASSERT_SAME(a_no_push_full, clock, reset, q_push, !q_status.full)
   // The back end only pops when it is idle and the queue holds an entry
   `R1MS_ASSERT_SAME(a_pop_ok, clock, reset, q_pop, !q_status.empty && back_status.idle)
   // A read result is a single transaction flagged last
   `R1MS_ASSERT_NEXT(a_read_last, clock, reset, back_status.load_read, rsp_tvalid && rsp_tlast)

endmodule

[design/r1ms_front.sv]
// ---------------------------------------------------------------------------
// Mirror request steering front end
// Accepts request transactions, forms the absolute sector and the new head
// position, and pushes the classified entry into the queue.
// ---------------------------------------------------------------------------
module r1ms_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: sector[31:0], partition_start[63:32], length_sectors[71:64]
   input  logic [r1ms_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode[0]
   input  logic                          req_tuser,
   input  r1ms_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output r1ms_pkg::req_entry_type       q_push_data
);
   import r1ms_pkg::*;

   logic                valid_ff, valid_in;
   req_entry_type       entry_ff, entry_in;
   logic                accept;
   logic [SECTOR_W-1:0] sector;
   logic [SECTOR_W-1:0] part_start;
   logic [LEN_W-1:0]    len;

   // Unpack the request fields
   assign sector     = req_tdata[31:0];
   assign part_start = req_tdata[63:32];
   assign len        = req_tdata[71:64];

   // Hold one entry; drain it into the queue when there is room
   assign q_push      = valid_ff && !q_status.full;
   assign req_tready  = !valid_ff || !q_status.full;
   assign accept      = req_tvalid && req_tready;
   assign q_push_data = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in            = 1'b1;
         entry_in.opcode     = req_tuser;
         entry_in.abs_sector = sector + part_start;
         entry_in.new_head   = sector + part_start + SECTOR_W'(len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[design/r1ms_queue.sv]
// ---------------------------------------------------------------------------
// Mirror request steering queue
// Short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module r1ms_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  r1ms_pkg::req_entry_type    push_data,
   input  logic                       pop,
   output r1ms_pkg::req_entry_type    pop_data,
   output r1ms_pkg::queue_status_type status
);
   import r1ms_pkg::*;

   req_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/r1ms_back.sv]
// ---------------------------------------------------------------------------
// Mirror request steering back end
// Sequencer that scans head positions for reads, fans writes out to every
// disk, and drives the registered result channel.
// ---------------------------------------------------------------------------
module r1ms_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [r1ms_pkg::DISK_CNT_W-1:0] disk_count,
   input  r1ms_pkg::queue_status_type      q_status,
   input  r1ms_pkg::req_entry_type         q_data,
   output logic                            q_pop,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   // tdata: disk_index[2:0], disk_sector[34:3], zero fill[39:35]
   output logic [r1ms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   output r1ms_pkg::back_status_type       status
);
   import r1ms_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [DISK_IDX_W-1:0] idx_ff, idx_in;
   logic [DISK_IDX_W-1:0] best_ff, best_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [DISK_IDX_W-1:0] tie_ff, tie_in;
   logic [SECTOR_W-1:0]   head_ff [MAX_DISKS];
   logic [SECTOR_W-1:0]   head_in [MAX_DISKS];
   req_entry_type         entry_ff, entry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DISK_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [SECTOR_W-1:0]   rsp_sector_ff, rsp_sector_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DISK_CNT_W-1:0] n_eff;
   logic [DISK_IDX_W-1:0] sel_idx;
   logic [SECTOR_W-1:0]   target;
   logic [DIST_W-1:0]     scan_dist;
   logic                  at_last_disk;
   logic                  load;

   // Saturated magnitude of the wrapped head-to-target difference
   function automatic logic [DIST_W-1:0] head_distance(input logic [SECTOR_W-1:0] head,
                                                       input logic [SECTOR_W-1:0] tgt);
      logic [SECTOR_W-1:0] d_fwd;
      logic [SECTOR_W-1:0] d_rev;
      logic [SECTOR_W-1:0] mag;
      d_fwd = head - tgt;
      d_rev = tgt - head;
      mag   = d_fwd[SECTOR_W-1] ? d_rev : d_fwd;
      if (mag[SECTOR_W-1:DIST_W] != '0) begin
         return DIST_LIMIT;
      end
      return mag[DIST_W-1:0];
   endfunction

   // Step the tie pointer modulo the disk count
   function automatic logic [DISK_IDX_W-1:0] tie_step(input logic [DISK_IDX_W-1:0] tp,
                                                      input logic [DISK_CNT_W-1:0] n);
      logic [DISK_CNT_W-1:0] r;
      r = DISK_CNT_W'(tp) + DISK_CNT_W'(1);
      for (int k = 0; k < MAX_DISKS; k++) begin
         if (r >= n) begin
            r = r - n;
         end
      end
      return r[DISK_IDX_W-1:0];
   endfunction

   assign n_eff        = eff_count(disk_count);
   assign sel_idx      = (state_ff == ST_IDLE) ? '0 : idx_ff;
   assign target       = (state_ff == ST_IDLE) ? q_data.abs_sector : entry_ff.abs_sector;
   assign scan_dist    = head_distance(head_ff[sel_idx], target);
   assign at_last_disk = (DISK_CNT_W'(idx_ff) == n_eff - DISK_CNT_W'(1));

   // Sequence one disk per cycle, holding in emit while the output is stalled
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      tie_in        = tie_ff;
      head_in       = head_ff;
      entry_in      = entry_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sector_in = rsp_sector_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      load          = 1'b0;

      // Drop the output transaction once taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               entry_in = q_data;
               if (q_data.opcode == OP_WRITE) begin
                  for (int k = 0; k < MAX_DISKS; k++) begin
                     if (DISK_CNT_W'(k) < n_eff) begin
                        head_in[k] = q_data.new_head;
                     end
                  end
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  best_in      = '0;
                  best_dist_in = scan_dist;
                  idx_in       = DISK_IDX_W'(1);
                  state_in     = (n_eff == DISK_CNT_W'(1)) ? ST_EMIT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_dist == best_dist_ff) begin
               if (tie_ff > best_ff && tie_ff <= idx_ff) begin
                  best_in = idx_ff;
               end
               tie_in = tie_step(tie_ff, n_eff);
            end else if (scan_dist < best_dist_ff) begin
               best_dist_in = scan_dist;
               best_in      = idx_ff;
            end
            if (at_last_disk) begin
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + DISK_IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load          = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_sector_in = entry_ff.abs_sector;
               if (entry_ff.opcode == OP_WRITE) begin
                  rsp_index_in = idx_ff;
                  rsp_last_in  = at_last_disk;
                  if (at_last_disk) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + DISK_IDX_W'(1);
                  end
               end else begin
                  rsp_index_in     = best_ff;
                  rsp_last_in      = 1'b1;
                  head_in[best_ff] = entry_ff.new_head;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         best_ff      <= '0;
         best_dist_ff <= '0;
         tie_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_DISKS; k++) begin
            head_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         best_ff      <= best_in;
         best_dist_ff <= best_dist_in;
         tie_ff       <= tie_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SECTOR_W - DISK_IDX_W)'(0), rsp_sector_ff, rsp_index_ff};

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.load      = load;
   assign status.load_read = load && (entry_ff.opcode == OP_READ);

endmodule
